// ===== rtl/spq_pkg.sv =====
// Package for the stable priority event queue: depth, codes, record and channel types.
package spq_pkg;

  // Queue depth (2..256) and count width derived from it
  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Request codes
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One held event record
  typedef struct packed {
    logic [7:0]         prio;
    logic [7:0]         event_code;
    logic signed [31:0] amount;
    logic [7:0]         source_id;
    logic [7:0]         resource_id;
  } rec_t;

  // Input channel payload
  typedef struct packed {
    logic               req_type;
    logic [7:0]         priority_req;
    logic [7:0]         event_code;
    logic signed [31:0] amount;
    logic [7:0]         source_id;
    logic [7:0]         resource_id;
  } in_t;

  // Result channel payload
  typedef struct packed {
    logic [1:0]         result_status;
    logic [7:0]         out_priority;
    logic [7:0]         out_event_code;
    logic signed [31:0] out_amount;
    logic [7:0]         out_source_id;
    logic [7:0]         out_resource_id;
  } out_t;

  // Broadcast to every cell for one transfer
  typedef struct packed {
    logic push_en;
    logic pop_en;
    rec_t new_rec;
  } cell_ctrl_t;

endpackage

// ===== rtl/stable_priority_event_queue.sv =====
// Top level of the stable priority event queue: cell chain, count and result register.
// Stable priority queue of event records held in a row of QUEUE_DEPTH cells, sorted
// with the head in cell 0. Every cell compares its priority with an incoming push in
// parallel, so the block accepts one request (push or pop) per clock whenever the
// result register is empty or being drained; the result is registered and appears in
// the cycle after acceptance. Each request yields exactly one result:
// a push returns status ok (fields zero) or full (record dropped), a pop returns the
// highest-priority record, oldest first among equal priorities, or status empty.
module stable_priority_event_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  spq_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output spq_pkg::out_t  out_data
);

  localparam int D = spq_pkg::QUEUE_DEPTH;
  localparam int W = spq_pkg::CNT_W;

  logic                  in_xfer;
  logic                  is_push;
  logic                  full;
  logic                  empty;
  logic [W-1:0]          count_r;
  logic [W-1:0]          count_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  spq_pkg::out_t         out_r;
  spq_pkg::out_t         out_nxt;
  spq_pkg::cell_ctrl_t   ctrl;
  spq_pkg::rec_t         cell_rec [D];
  logic [D-1:0]          cell_after;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign is_push   = (in_data.req_type == spq_pkg::REQ_PUSH);
  assign full      = (count_r == W'(D));
  assign empty     = (count_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Broadcast request to the cells
  always_comb begin
    ctrl.push_en             = in_xfer && is_push && !full;
    ctrl.pop_en              = in_xfer && !is_push && !empty;
    ctrl.new_rec.prio        = in_data.priority_req;
    ctrl.new_rec.event_code  = in_data.event_code;
    ctrl.new_rec.amount      = in_data.amount;
    ctrl.new_rec.source_id   = in_data.source_id;
    ctrl.new_rec.resource_id = in_data.resource_id;
  end

  // Cell chain
  for (genvar i = 0; i < D; i++) begin : g_cell
    spq_pkg::rec_t left_rec;
    spq_pkg::rec_t right_rec;
    logic          left_after;

    if (i == 0) begin : g_head
      assign left_rec   = ctrl.new_rec;
      assign left_after = 1'b1;
    end else begin : g_mid
      assign left_rec   = cell_rec[i-1];
      assign left_after = cell_after[i-1];
    end

    if (i == D - 1) begin : g_tail
      assign right_rec = ctrl.new_rec;
    end else begin : g_body
      assign right_rec = cell_rec[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (count_r > W'(i)),
      .left_rec   (left_rec),
      .left_after (left_after),
      .right_rec  (right_rec),
      .rec_o      (cell_rec[i]),
      .after_o    (cell_after[i])
    );
  end

  // Count and result register
  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctrl.push_en) begin
      count_nxt = count_r + W'(1);
    end else if (ctrl.pop_en) begin
      count_nxt = count_r - W'(1);
    end
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      if (is_push) begin
        out_nxt.result_status = full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
      end else if (empty) begin
        out_nxt.result_status = spq_pkg::ST_EMPTY;
      end else begin
        out_nxt.result_status   = spq_pkg::ST_OK;
        out_nxt.out_priority    = cell_rec[0].prio;
        out_nxt.out_event_code  = cell_rec[0].event_code;
        out_nxt.out_amount      = cell_rec[0].amount;
        out_nxt.out_source_id   = cell_rec[0].source_id;
        out_nxt.out_resource_id = cell_rec[0].resource_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

endmodule

// ===== rtl/spq_cell.sv =====
// One cell of the sorted shift-register queue.
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic               occ,
  input  spq_pkg::rec_t      left_rec,
  input  logic               left_after,
  input  spq_pkg::rec_t      right_rec,
  output spq_pkg::rec_t      rec_o,
  output logic               after_o
);

  spq_pkg::rec_t rec_r;
  spq_pkg::rec_t rec_nxt;

  // New record belongs behind this one when held priority is equal or higher
  assign after_o = occ && (rec_r.prio >= ctrl.new_rec.prio);
  assign rec_o   = rec_r;

  // Keep, take the new record, or shift from a neighbor
  always_comb begin
    rec_nxt = rec_r;
    if (ctrl.push_en) begin
      if (!after_o) begin
        rec_nxt = left_after ? ctrl.new_rec : left_rec;
      end
    end else if (ctrl.pop_en) begin
      rec_nxt = right_rec;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the stable priority event queue: record model, drivers, checks.
import spq_pkg::*;

// Sorted record store with the expected results of accepted requests
class spq_scoreboard;
  rec_t        held[QUEUE_DEPTH];
  int unsigned held_count;
  out_t        expected_results[$];
  int unsigned errors;
  int unsigned pushes_ok, pushes_full, pops_ok, pops_empty;

  function new();
    held_count = 0;
    errors = 0;
    pushes_ok = 0;
    pushes_full = 0;
    pops_ok = 0;
    pops_empty = 0;
  endfunction

  // Apply one accepted request to the store and queue its result
  function void note_request(in_t req);
    out_t        res;
    rec_t        rec;
    int unsigned pos;
    int unsigned i;
    res = '0;
    if (req.req_type == REQ_PUSH) begin
      if (held_count >= QUEUE_DEPTH) begin
        res.result_status = ST_FULL;
        pushes_full++;
      end else begin
        rec.prio        = req.priority_req;
        rec.event_code  = req.event_code;
        rec.amount      = req.amount;
        rec.source_id   = req.source_id;
        rec.resource_id = req.resource_id;
        // land behind every record of equal or higher priority
        pos = 0;
        while (pos < held_count && held[pos].prio >= rec.prio) pos++;
        for (i = held_count; i > pos; i--) held[i] = held[i - 1];
        held[pos] = rec;
        held_count++;
        res.result_status = ST_OK;
        pushes_ok++;
      end
    end else begin
      if (held_count == 0) begin
        res.result_status = ST_EMPTY;
        pops_empty++;
      end else begin
        rec = held[0];
        for (i = 1; i < held_count; i++) held[i - 1] = held[i];
        held_count--;
        res.result_status   = ST_OK;
        res.out_priority    = rec.prio;
        res.out_event_code  = rec.event_code;
        res.out_amount      = rec.amount;
        res.out_source_id   = rec.source_id;
        res.out_resource_id = rec.resource_id;
        pops_ok++;
      end
    end
    expected_results.push_back(res);
  endfunction

  function void check_field(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endfunction

  // Compare one result transfer with the oldest expectation
  function void check_result(out_t got);
    out_t exp_res;
    if (expected_results.size() == 0) begin
      $error("result transfer with no request outstanding: status %0d", got.result_status);
      errors++;
    end else begin
      exp_res = expected_results.pop_front();
      check_field("result_status", exp_res.result_status, got.result_status);
      check_field("out_priority", exp_res.out_priority, got.out_priority);
      check_field("out_event_code", exp_res.out_event_code, got.out_event_code);
      check_field("out_amount", $signed(exp_res.out_amount), $signed(got.out_amount));
      check_field("out_source_id", exp_res.out_source_id, got.out_source_id);
      check_field("out_resource_id", exp_res.out_resource_id, got.out_resource_id);
    end
  endfunction

  function int unsigned outstanding();
    return expected_results.size();
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1625;
  localparam int unsigned TOTAL_ITEMS  = RANDOM_ITEMS + 24;
  localparam int unsigned CALM_ITEMS   = 300;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  spq_scoreboard sb = new();
  int unsigned   accepted_items = 0;
  bit            calm = 1'b0;
  bit            long_hold_done = 1'b0;

  stable_priority_event_queue DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // Run limit
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  // Monitor: check result transfers, then record request transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_request(in_data);
    end
  end

  // Receiver: random stall bursts plus one long hold-off so the queue backs up
  initial begin
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!long_hold_done && accepted_items >= 400) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  function automatic logic signed [31:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return 32'shffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t make_push(logic [7:0] prio);
    in_t req;
    req.req_type     = REQ_PUSH;
    req.priority_req = prio;
    req.event_code   = 8'($urandom);
    req.amount       = pick_amount();
    req.source_id    = 8'($urandom);
    req.resource_id  = 8'($urandom);
    return req;
  endfunction

  // Pop requests carry random data, which the block must ignore
  function automatic in_t make_pop();
    in_t req;
    req = make_push(8'($urandom));
    req.req_type = REQ_POP;
    return req;
  endfunction

  function automatic in_t make_record(logic [7:0] prio, logic [7:0] code,
                                      logic signed [31:0] amt, logic [7:0] src,
                                      logic [7:0] res);
    in_t req;
    req.req_type     = REQ_PUSH;
    req.priority_req = prio;
    req.event_code   = code;
    req.amount       = amt;
    req.source_id    = src;
    req.resource_id  = res;
    return req;
  endfunction

  // Offer one request and hold it until the transfer
  task automatic send_item(in_t item);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    accepted_items++;
    if (accepted_items >= TOTAL_ITEMS - CALM_ITEMS) calm = 1'b1;
  endtask

  initial begin
    int unsigned n;
    int unsigned push_pct;
    logic [7:0]  prio;
    in_valid <= 1'b0;
    in_data  <= '0;
    rst_n    <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, extreme records, ties, a full queue, then a few pops
    send_item(make_pop());
    send_item(make_record(8'd255, 8'd0, 32'sh8000_0000, 8'd0, 8'd255));
    send_item(make_record(8'd0, 8'd255, 32'sh7fff_ffff, 8'd255, 8'd0));
    send_item(make_record(8'd128, 8'd1, 32'sd1, 8'd1, 8'd1));
    send_item(make_record(8'd128, 8'd2, 32'sd2, 8'd2, 8'd2));
    send_item(make_record(8'd128, 8'd3, -32'sd3, 8'd3, 8'd3));
    send_item(make_record(8'd255, 8'd4, 32'sh7fff_ffff, 8'd4, 8'd4));
    send_item(make_record(8'd0, 8'd5, 32'sh8000_0000, 8'd5, 8'd5));
    for (n = 0; n < 9; n++) send_item(make_push(8'($urandom_range(0, 3) * 85)));
    send_item(make_record(8'd255, 8'd255, 32'shffff_ffff, 8'd255, 8'd255));
    for (n = 0; n < 6; n++) send_item(make_pop());

    // Random: phases that fill, drain and hover, with narrow and wide priorities
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 120) % 4)
        0:       push_pct = 50;
        1:       push_pct = 80;
        2:       push_pct = 25;
        default: push_pct = 55;
      endcase
      case ((n / 40) % 3)
        0:       prio = 8'($urandom_range(0, 3));
        1:       prio = 8'($urandom);
        default: prio = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      endcase
      if ($urandom_range(1, 100) <= push_pct) send_item(make_push(prio));
      else send_item(make_pop());
    end
    in_valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d requests: %0d pushes stored, %0d pushes refused as full,",
             accepted_items, sb.pushes_ok, sb.pushes_full);
    $display("%0d records popped, %0d pops on an empty queue.", sb.pops_ok, sb.pops_empty);
    if (sb.outstanding() != 0) begin
      $error("%0d results never arrived", sb.outstanding());
    end
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_event_queue.sv
tb/sv/tb.sv
